// File: design/truncated_polylog_term_macros.svh
// Assertion helpers used by the top-level design file.
// Each macro expects i_clk and i_rst_n in scope.
`ifndef TRUNCATED_POLYLOG_TERM_MACROS_SVH
`define TRUNCATED_POLYLOG_TERM_MACROS_SVH

// same-cycle implication
`define TPL_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tpl: same-cycle check failed");

// next-cycle implication
`define TPL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tpl: next-cycle check failed");

`endif

// File: design/tpl_pkg.sv
`default_nettype none

package tpl_pkg;

    // design limits
    localparam int MAX_TERMS = 64;
    localparam int MAX_ORDER = 8;

    // field widths
    localparam int IDX_W    = 16;
    localparam int RATE_W   = 17;
    localparam int TERMS_W  = 7;
    localparam int ORDER_W  = 4;
    localparam int WEIGHT_W = 24;
    localparam int RES_W    = 32;
    localparam int CFG_IDX_W = 2;

    // internal widths
    localparam int K_W     = $clog2(MAX_TERMS + 1);
    localparam int CNT_W   = (K_W > 5) ? K_W : 5;        // also holds the log term index
    localparam int J_W     = $clog2(MAX_ORDER + 1);
    localparam int P_W     = 33;                         // Q0.32 power, 1.0 included
    localparam int DVS_W   = 34;                         // saturating divisor
    localparam int DVD_W   = RATE_W + 32;                // r << 32
    localparam int DIV_CNT_W = $clog2(DVD_W + 1);
    localparam int ACC_W   = 35;
    localparam int MUL_A_W = P_W;
    localparam int MUL_B_W = 32;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int DK_W    = DVS_W + CNT_W;
    localparam int MAG_W   = 32;
    localparam int ADDR_W  = 5;

    // constants
    localparam logic [RATE_W-1:0] RATE_ONE  = 17'd65536;   // 1.0 in Q1.16
    localparam logic [DVS_W-1:0]  LOG_BASE  = 34'd131072;  // 2.0 in Q18.16
    localparam int                LOG_TERMS = 16;
    localparam logic [55:0]       ROUND_HALF = 56'd8388608; // 0.5 LSB of Q.24
    localparam logic [MAG_W-1:0]  MAG_NEG_MAX = 32'h8000_0000;
    localparam logic [MAG_W-1:0]  MAG_POS_MAX = 32'h7FFF_FFFF;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TERM_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SERIES_ORDER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT       = 2'd2;

    // datapath operations
    typedef enum logic [4:0] {
        OP_NOP,
        OP_SER_INIT,
        OP_D_INIT,
        OP_D_MUL,
        OP_SER_DIV,
        OP_SER_ACC,
        OP_SER_NEXT,
        OP_LOG_INIT,
        OP_LOG_Z,
        OP_MUL_ZZ,
        OP_LOG_Z2,
        OP_LOG_DIV,
        OP_LOG_ACC,
        OP_LOG_FIN,
        OP_OUT_MUL,
        OP_OUT_RND,
        OP_OUT_WRITE
    } t_op;

    // jump conditions
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_START,
        C_ORDER_ONE,
        C_J_MORE,
        C_DIV_BUSY,
        C_K_MORE,
        C_N_MORE,
        C_OUT_FULL
    } t_cond;

    typedef struct packed {
        t_op                op;
        t_cond              cond;
        logic [ADDR_W-1:0]  target;
    } t_uword;

    typedef struct packed {
        logic order_one;
        logic j_more;
        logic k_more;
        logic n_more;
        logic div_busy;
    } t_dp_status;

    // program addresses
    localparam logic [ADDR_W-1:0] A_IDLE   = 5'd0;
    localparam logic [ADDR_W-1:0] A_TERM   = 5'd2;
    localparam logic [ADDR_W-1:0] A_DMUL   = 5'd3;
    localparam logic [ADDR_W-1:0] A_SWAIT  = 5'd5;
    localparam logic [ADDR_W-1:0] A_LOG    = 5'd9;
    localparam logic [ADDR_W-1:0] A_LWAIT0 = 5'd10;
    localparam logic [ADDR_W-1:0] A_LTERM  = 5'd14;
    localparam logic [ADDR_W-1:0] A_LWAIT  = 5'd15;
    localparam logic [ADDR_W-1:0] A_OUT    = 5'd18;
    localparam logic [ADDR_W-1:0] A_OWAIT  = 5'd20;

    // control store; the condition picks target, otherwise the next step
    function automatic t_uword ucode(input logic [ADDR_W-1:0] addr);
        t_uword w;
        case (addr)
            5'd0:  w = '{OP_NOP,       C_NO_START,  A_IDLE};
            5'd1:  w = '{OP_SER_INIT,  C_ORDER_ONE, A_LOG};
            5'd2:  w = '{OP_D_INIT,    C_NEVER,     A_IDLE};
            5'd3:  w = '{OP_D_MUL,     C_J_MORE,    A_DMUL};
            5'd4:  w = '{OP_SER_DIV,   C_NEVER,     A_IDLE};
            5'd5:  w = '{OP_NOP,       C_DIV_BUSY,  A_SWAIT};
            5'd6:  w = '{OP_SER_ACC,   C_NEVER,     A_IDLE};
            5'd7:  w = '{OP_SER_NEXT,  C_K_MORE,    A_TERM};
            5'd8:  w = '{OP_NOP,       C_ALWAYS,    A_OUT};
            5'd9:  w = '{OP_LOG_INIT,  C_NEVER,     A_IDLE};
            5'd10: w = '{OP_NOP,       C_DIV_BUSY,  A_LWAIT0};
            5'd11: w = '{OP_LOG_Z,     C_NEVER,     A_IDLE};
            5'd12: w = '{OP_MUL_ZZ,    C_NEVER,     A_IDLE};
            5'd13: w = '{OP_LOG_Z2,    C_NEVER,     A_IDLE};
            5'd14: w = '{OP_LOG_DIV,   C_NEVER,     A_IDLE};
            5'd15: w = '{OP_NOP,       C_DIV_BUSY,  A_LWAIT};
            5'd16: w = '{OP_LOG_ACC,   C_N_MORE,    A_LTERM};
            5'd17: w = '{OP_LOG_FIN,   C_NEVER,     A_IDLE};
            5'd18: w = '{OP_OUT_MUL,   C_NEVER,     A_IDLE};
            5'd19: w = '{OP_OUT_RND,   C_NEVER,     A_IDLE};
            5'd20: w = '{OP_NOP,       C_OUT_FULL,  A_OWAIT};
            5'd21: w = '{OP_OUT_WRITE, C_ALWAYS,    A_IDLE};
            default: w = '{OP_NOP,     C_ALWAYS,    A_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// File: design/truncated_polylog_term.sv
// Channel  | Handshake                   | Payload
// ---------+-----------------------------+----------------------------------
// input    | i_in_valid / o_in_stall     | i_sample_index, i_rate
// output   | o_out_valid / i_out_stall   | o_result_index, o_term_value
// config   | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//
// One item at a time. Order one (log form): between acceptance and the result write, nearly
// all of the time goes to seventeen runs of the shared divider.
// Higher orders: per term, series_order - 1 multiplies build k^order, then the divider runs.
// Reset (sync, active low) idles the sequencer, empties the output register, loads
// 16 / 2 / 1.0 and holds off input and register writes; a stalled result blocks the next write.
`default_nettype none

`include "truncated_polylog_term_macros.svh"

module truncated_polylog_term (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // input transactions
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_stall,
    input  wire logic [tpl_pkg::IDX_W-1:0]             i_sample_index,
    input  wire logic [tpl_pkg::RATE_W-1:0]            i_rate,
    // result transactions
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_stall,
    output logic [tpl_pkg::IDX_W-1:0]                  o_result_index,
    output logic signed [tpl_pkg::RES_W-1:0]           o_term_value,
    // register writes
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [tpl_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [tpl_pkg::WEIGHT_W-1:0]          i_cfg_data
);
    import tpl_pkg::*;

    // configuration registers
    logic [TERMS_W-1:0]          r_term_count;
    logic [ORDER_W-1:0]          r_series_order;
    logic signed [WEIGHT_W-1:0]  r_weight;

    // item index and output register
    logic [IDX_W-1:0]            r_idx;
    logic                        r_out_valid;
    logic [IDX_W-1:0]            r_result_index;
    logic [RES_W-1:0]            r_term_value;

    logic        w_accept;
    logic        w_drain;
    logic        w_out_full;
    logic        w_idle;
    t_uword      w_uword;
    t_dp_status  w_dp_status;
    logic [RES_W-1:0] w_value;

    // an item enters only while the sequencer sits at its idle step, never in reset
    assign o_in_stall  = !w_idle || !i_rst_n;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_drain     = r_out_valid && !i_out_stall;
    // a result that leaves this cycle frees the register for the next write
    assign w_out_full  = r_out_valid && i_out_stall;
    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term_count   <= 7'd16;
            r_series_order <= 4'd2;
            r_weight       <= 24'sd65536;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_TERM_COUNT:   r_term_count   <= i_cfg_data[TERMS_W-1:0];
                CFG_SERIES_ORDER: r_series_order <= i_cfg_data[ORDER_W-1:0];
                CFG_WEIGHT:       r_weight       <= $signed(i_cfg_data);
                default:          r_weight       <= r_weight;  // unknown index ignored
            endcase
        end
    end

    tpl_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_accept),
        .i_out_full (w_out_full),
        .i_status   (w_dp_status),
        .o_uword    (w_uword),
        .o_idle     (w_idle)
    );

    tpl_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (w_accept),
        .i_rate         (i_rate),
        .i_term_count   (r_term_count),
        .i_series_order (r_series_order),
        .i_weight       (r_weight),
        .i_uword        (w_uword),
        .o_status       (w_dp_status),
        .o_value        (w_value)
    );

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_idx <= i_sample_index;
        end
        if (w_uword.op == OP_OUT_WRITE) begin
            r_result_index <= r_idx;
            r_term_value   <= w_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_uword.op == OP_OUT_WRITE) begin
            r_out_valid <= 1'b1;
        end else if (w_drain) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_result_index = r_result_index;
    assign o_term_value   = $signed(r_term_value);

    // a result shows up only after the write step
    `TPL_ASSERT_IMPL(a_out_from_write, $rose(o_out_valid), $past(w_uword.op == OP_OUT_WRITE))
    // the write step never lands on a result still held by the consumer
    `TPL_ASSERT_IMPL(a_no_overwrite, w_uword.op == OP_OUT_WRITE, !w_out_full)
    // an accepted transaction closes the input until its result is written
    `TPL_ASSERT_NEXT(a_stall_after_accept, w_accept, o_in_stall)
    // the divider is never relaunched mid-division
    `TPL_ASSERT_IMPL(a_div_free, w_uword.op == OP_SER_DIV || w_uword.op == OP_LOG_INIT || w_uword.op == OP_LOG_DIV, !w_dp_status.div_busy)

endmodule

`default_nettype wire

// File: design/tpl_div.sv
`default_nettype none

// restoring divider, one quotient bit per cycle
module tpl_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [tpl_pkg::DVD_W-1:0]   i_dividend,
    input  wire logic [tpl_pkg::DVS_W-1:0]   i_divisor,
    output logic                             o_busy,
    output logic [tpl_pkg::DVD_W-1:0]        o_quotient
);
    import tpl_pkg::*;

    logic                  r_busy;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic [DVS_W-1:0]      r_rem;
    logic [DVS_W-1:0]      r_dvs;
    logic [DVD_W-1:0]      r_quo;

    logic [DVS_W:0]        w_shift;
    logic [DVS_W:0]        w_diff;
    logic                  w_ge;
    logic [DVS_W-1:0]      n_rem;

    always_comb begin
        w_shift = {r_rem, r_quo[DVD_W-1]};
        w_ge    = (w_shift >= {1'b0, r_dvs});
        w_diff  = w_shift - {1'b0, r_dvs};
        n_rem   = w_ge ? w_diff[DVS_W-1:0] : w_shift[DVS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_CNT_W'(DVD_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == DIV_CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[DVD_W-2:0], w_ge};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// File: design/tpl_dp.sv
`default_nettype none

// datapath: one multiplier, the divider, power/accumulator registers
module tpl_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_load,
    input  wire logic [tpl_pkg::RATE_W-1:0]    i_rate,
    input  wire logic [tpl_pkg::TERMS_W-1:0]   i_term_count,
    input  wire logic [tpl_pkg::ORDER_W-1:0]   i_series_order,
    input  wire logic signed [tpl_pkg::WEIGHT_W-1:0] i_weight,
    input  wire tpl_pkg::t_uword               i_uword,
    output tpl_pkg::t_dp_status                o_status,
    output logic [tpl_pkg::RES_W-1:0]          o_value
);
    import tpl_pkg::*;

    logic [RATE_W-1:0]        r_rate;
    logic [K_W-1:0]           r_terms;
    logic [J_W-1:0]           r_order;
    logic [CNT_W-1:0]         r_k;
    logic [J_W-1:0]           r_j;
    logic [P_W-1:0]           r_p;
    logic [DVS_W-1:0]         r_d;
    logic [31:0]              r_z2;
    logic signed [ACC_W-1:0]  r_acc;
    logic [PROD_W-1:0]        r_prod;
    logic                     r_neg;
    logic [MAG_W-1:0]         r_mag;

    logic [RATE_W-1:0]        n_rate;
    logic [K_W-1:0]           n_terms;
    logic [J_W-1:0]           n_order;

    logic [MUL_A_W-1:0]       w_mul_a;
    logic [MUL_B_W-1:0]       w_mul_b;
    logic                     w_mul_en;
    logic [PROD_W-1:0]        w_prod;
    logic [DK_W-1:0]          w_dk;
    logic [DVS_W-1:0]         w_dk_sat;
    logic signed [ACC_W-1:0]  w_acc_abs;
    logic [WEIGHT_W-1:0]      w_w_abs;
    logic [55:0]              w_rnd;
    logic [MAG_W-1:0]         w_sat;

    logic                     w_div_start;
    logic [DVD_W-1:0]         w_dividend;
    logic [DVS_W-1:0]         w_divisor;
    logic                     w_div_busy;
    logic [DVD_W-1:0]         w_quo;

    tpl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_busy     (w_div_busy),
        .o_quotient (w_quo)
    );

    // clamp item and registers at load
    always_comb begin
        n_rate = (i_rate > RATE_ONE) ? RATE_ONE : i_rate;
        if (i_term_count == '0) begin
            n_terms = K_W'(1);
        end else if (32'(i_term_count) > 32'(MAX_TERMS)) begin
            n_terms = K_W'(MAX_TERMS);
        end else begin
            n_terms = K_W'(i_term_count);
        end
        if (i_series_order == '0) begin
            n_order = J_W'(1);
        end else if (32'(i_series_order) > 32'(MAX_ORDER)) begin
            n_order = J_W'(MAX_ORDER);
        end else begin
            n_order = J_W'(i_series_order);
        end
    end

    always_comb begin
        w_acc_abs = r_acc[ACC_W-1] ? -r_acc : r_acc;
        w_w_abs   = i_weight[WEIGHT_W-1] ? WEIGHT_W'(-i_weight) : WEIGHT_W'(i_weight);
    end

    // operand select for the shared multiplier
    always_comb begin
        w_mul_a  = '0;
        w_mul_b  = '0;
        w_mul_en = 1'b0;
        case (i_uword.op)
            OP_SER_ACC: begin
                w_mul_a  = r_p;
                w_mul_b  = MUL_B_W'(r_rate);
                w_mul_en = 1'b1;
            end
            OP_MUL_ZZ: begin
                w_mul_a  = r_p;
                w_mul_b  = r_p[31:0];
                w_mul_en = 1'b1;
            end
            OP_LOG_DIV: begin
                w_mul_a  = r_p;
                w_mul_b  = r_z2;
                w_mul_en = 1'b1;
            end
            OP_OUT_MUL: begin
                w_mul_a  = w_acc_abs[P_W-1:0];
                w_mul_b  = MUL_B_W'(w_w_abs);
                w_mul_en = 1'b1;
            end
            default: begin
                w_mul_en = 1'b0;
            end
        endcase
        w_prod = PROD_W'(w_mul_a) * PROD_W'(w_mul_b);
    end

    // divider launch
    always_comb begin
        w_div_start = 1'b0;
        w_dividend  = DVD_W'(r_p);
        w_divisor   = r_d;
        case (i_uword.op)
            OP_SER_DIV: begin
                w_div_start = 1'b1;
            end
            OP_LOG_INIT: begin
                w_div_start = 1'b1;
                w_dividend  = {r_rate, 32'd0};
                w_divisor   = LOG_BASE + DVS_W'(r_rate);
            end
            OP_LOG_DIV: begin
                w_div_start = 1'b1;
                w_divisor   = DVS_W'({r_k, 1'b1});
            end
            default: begin
                w_div_start = 1'b0;
            end
        endcase
    end

    // k^order; once past the largest power it pins high and the quotient is zero
    always_comb begin
        w_dk     = DK_W'(r_d) * DK_W'(r_k);
        w_dk_sat = (|w_dk[DK_W-1:DVS_W]) ? '1 : w_dk[DVS_W-1:0];
        w_rnd    = r_prod[55:0] + ROUND_HALF;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rate  <= n_rate;
            r_terms <= n_terms;
            r_order <= n_order;
        end
        if (w_mul_en) begin
            r_prod <= w_prod;
        end
        case (i_uword.op)
            OP_SER_INIT: begin
                r_p   <= P_W'({r_rate, 16'd0});
                r_acc <= '0;
                r_k   <= CNT_W'(1);
            end
            OP_D_INIT: begin
                r_d <= DVS_W'(r_k);
                r_j <= J_W'(1);
            end
            OP_D_MUL: begin
                r_d <= w_dk_sat;
                r_j <= r_j + 1'b1;
            end
            OP_SER_ACC: begin
                if (r_k[0]) begin
                    r_acc <= r_acc - $signed({2'b00, w_quo[P_W-1:0]});
                end else begin
                    r_acc <= r_acc + $signed({2'b00, w_quo[P_W-1:0]});
                end
            end
            OP_SER_NEXT: begin
                r_p <= r_prod[16 +: P_W];
                r_k <= r_k + 1'b1;
            end
            OP_LOG_INIT: begin
                r_acc <= '0;
                r_k   <= '0;
            end
            OP_LOG_Z: begin
                r_p <= P_W'(w_quo[31:0]);
            end
            OP_LOG_Z2: begin
                r_z2 <= r_prod[63:32];
            end
            OP_LOG_ACC: begin
                r_acc <= r_acc + $signed({3'b000, w_quo[31:0]});
                r_p   <= r_prod[32 +: P_W];
                r_k   <= r_k + 1'b1;
            end
            OP_LOG_FIN: begin
                r_acc <= -(r_acc <<< 1);
            end
            OP_OUT_MUL: begin
                r_neg <= r_acc[ACC_W-1] ^ i_weight[WEIGHT_W-1];
            end
            OP_OUT_RND: begin
                r_mag <= w_rnd[55:24];
            end
            default: begin
                r_k <= r_k;
            end
        endcase
    end

    // saturate and restore the sign
    always_comb begin
        if (r_neg) begin
            w_sat   = (r_mag > MAG_NEG_MAX) ? MAG_NEG_MAX : r_mag;
            o_value = RES_W'(-w_sat);
        end else begin
            w_sat   = (r_mag > MAG_POS_MAX) ? MAG_POS_MAX : r_mag;
            o_value = RES_W'(w_sat);
        end
    end

    always_comb begin
        o_status.order_one = (r_order == J_W'(1));
        o_status.j_more    = ((J_W + 1)'(r_j) + 1'b1) < (J_W + 1)'(r_order);
        o_status.k_more    = (r_k < CNT_W'(r_terms));
        o_status.n_more    = (r_k < CNT_W'(LOG_TERMS - 1));
        o_status.div_busy  = w_div_busy;
    end

endmodule

`default_nettype wire

// File: design/tpl_seq.sv
`default_nettype none

// step counter over the control store
module tpl_seq (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic                 i_out_full,
    input  wire tpl_pkg::t_dp_status  i_status,
    output tpl_pkg::t_uword           o_uword,
    output logic                      o_idle
);
    import tpl_pkg::*;

    logic [ADDR_W-1:0] r_pc;
    logic [ADDR_W-1:0] n_pc;
    t_uword            w_uword;
    logic              w_take;

    // outputs
    always_comb begin
        w_uword = ucode(r_pc);
        o_uword = w_uword;
        o_idle  = (r_pc == A_IDLE);
    end

    // next step
    always_comb begin
        case (w_uword.cond)
            C_NEVER:     w_take = 1'b0;
            C_ALWAYS:    w_take = 1'b1;
            C_NO_START:  w_take = !i_start;
            C_ORDER_ONE: w_take = i_status.order_one;
            C_J_MORE:    w_take = i_status.j_more;
            C_DIV_BUSY:  w_take = i_status.div_busy;
            C_K_MORE:    w_take = i_status.k_more;
            C_N_MORE:    w_take = i_status.n_more;
            C_OUT_FULL:  w_take = i_out_full;
            default:     w_take = 1'b1;
        endcase
        n_pc = w_take ? w_uword.target : r_pc + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= A_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

`default_nettype wire
